// ===== rtl/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types and constants for the streaming SHA-256 hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha_pkg;

  // one input request
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
  } in_item_t;

  // one digest word
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // round constants
  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // initial chaining values
  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte  = 8'h80;
  localparam int unsigned LenStart = 56;

  function automatic logic [31:0] rotr(logic [31:0] x, int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sha256_stream_hash.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hash
// Streaming SHA-256 hasher with queue-style ports on both sides.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle into a small queue while the core appends
// them to a 64-byte block. Every 64th byte starts the compression: one round
// per cycle from a single shared round unit, during which the queue fills and
// then full rises. A last request pads, spilling into a second block when the
// length does not fit, compresses one or two more blocks and then offers the
// eight digest words; all state returns to the initial hash values after the
// eighth word is popped.
`default_nettype none

module sha256_stream_hash
  import sha_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  output logic           full_o,
  input  wire in_item_t  in_item_i,
  output logic           empty_o,
  input  wire logic      pop_i,
  output out_item_t      out_item_o
);

  logic     f_push, q_full, q_empty, q_pop;
  in_item_t f_item, q_item;

  sha_front u_front (
    .clk_i, .rst_ni, .push_i, .full_o, .in_item_i,
    .q_push_o(f_push), .q_full_i(q_full), .q_item_o(f_item)
  );

  sha_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .push_i(f_push), .full_o(q_full), .item_i(f_item),
    .pop_i(q_pop), .empty_o(q_empty), .item_o(q_item)
  );

  sha_core u_core (
    .clk_i, .rst_ni,
    .q_empty_i(q_empty), .q_pop_o(q_pop), .q_item_i(q_item),
    .empty_o, .pop_i, .out_item_o
  );

endmodule

`default_nettype wire

// ===== rtl/sha_front.sv =====
// ----------------------------------------------------------------------------
// sha_front
// Front end: takes input requests and drops idle ones before the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_front
  import sha_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  output logic          full_o,
  input  wire in_item_t in_item_i,
  // queue side
  output logic          q_push_o,
  input  wire logic     q_full_i,
  output in_item_t      q_item_o
);

  logic     vld_q;
  in_item_t item_q;
  logic     take;

  assign take     = vld_q && !q_full_i;
  assign full_o   = vld_q && !take;
  assign q_push_o = take;
  assign q_item_o = item_q;

  // staging register, keeps only requests that do something
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (push_i && !full_o) begin
      vld_q <= in_item_i.byte_valid || in_item_i.last;
    end else if (take) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sha_queue.sv =====
// ----------------------------------------------------------------------------
// sha_queue
// Small request queue between the front end and the hashing core.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_queue
  import sha_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  output logic          full_o,
  input  wire in_item_t item_i,
  input  wire logic     pop_i,
  output logic          empty_o,
  output in_item_t      item_o
);

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  in_item_t        mem_q [Depth];
  logic [Aw-1:0]   wr_q, rd_q;
  logic [Aw:0]     cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == (Aw+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_q];

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == Aw'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == Aw'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (Aw+1)'(do_push) - (Aw+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sha_core.sv =====
// ----------------------------------------------------------------------------
// sha_core
// Back end: block buffer, padding, 64-round compression and digest output.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_core
  import sha_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      q_empty_i,
  output logic           q_pop_o,
  input  wire in_item_t  q_item_i,
  output logic           empty_o,
  input  wire logic      pop_i,
  output out_item_t      out_item_o
);

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StPad   = 6'b000010,
    StLen   = 6'b000100,
    StRound = 6'b001000,
    StAdd   = 6'b010000,
    StOut   = 6'b100000
  } state_e;

  state_e        state_q, state_d;
  logic [31:0]   h_q [8];
  logic [31:0]   v_q [8];
  logic [31:0]   w_q [16];
  logic [5:0]    fill_q;
  logic [63:0]   bits_q;
  logic [5:0]    rnd_q;
  logic [2:0]    oidx_q;
  logic          fin_q;     // finishing a message
  logic          lenblk_q;  // current compression is the final one
  logic          pad_q;     // pad byte not yet placed

  // byte write into the block buffer, kept as 16 big-endian words
  logic          wr_en;
  logic [5:0]    wr_addr;
  logic [7:0]    wr_byte;

  // message schedule and round datapath
  logic [31:0]   s0, s1, w_new, w_cur;
  logic [31:0]   t1, t2;

  assign w_cur = w_q[0];
  assign s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
  assign w_new = w_q[0] + s0 + w_q[9] + s1;
  assign t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
            + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + RoundK[rnd_q] + w_cur;
  assign t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
            + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  assign q_pop_o = (state_q == StIdle) && !q_empty_i;
  assign empty_o = (state_q != StOut);
  assign out_item_o.digest_word = h_q[oidx_q];
  assign out_item_o.word_index  = oidx_q;
  assign out_item_o.last_word   = (oidx_q == 3'd7);

  // byte write source
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill_q;
    wr_byte = q_item_i.data_byte;
    unique case (state_q)
      StIdle: wr_en = q_pop_o && q_item_i.byte_valid;
      StPad: begin
        wr_en   = 1'b1;
        wr_byte = pad_q ? PadByte : 8'h00;
      end
      StLen: begin
        wr_en   = 1'b1;
        wr_byte = bits_q[8*(63 - fill_q) +: 8];
      end
      default: wr_en = 1'b0;
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (q_pop_o) begin
          if (q_item_i.byte_valid && fill_q == 6'd63) state_d = StRound;
          else if (q_item_i.last) state_d = StPad;
        end
      end
      StPad: begin
        if (fill_q == 6'd63) state_d = StRound;
        else if (fill_q == 6'(LenStart - 1)) state_d = StLen;
      end
      StLen:   if (fill_q == 6'd63) state_d = StRound;
      StRound: if (rnd_q == 6'd63) state_d = StAdd;
      StAdd: begin
        if (lenblk_q) state_d = StOut;
        else if (fin_q) state_d = StPad;
        else state_d = StIdle;
      end
      StOut:   if (pop_i && oidx_q == 3'd7) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      fill_q   <= '0;
      bits_q   <= '0;
      rnd_q    <= '0;
      oidx_q   <= '0;
      fin_q    <= 1'b0;
      lenblk_q <= 1'b0;
      pad_q    <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
    end else begin
      state_q <= state_d;
      if (wr_en) fill_q <= fill_q + 6'd1;
      unique case (state_q)
        StIdle: begin
          if (q_pop_o) begin
            if (q_item_i.byte_valid) bits_q <= bits_q + 64'd8;
            fin_q    <= q_item_i.last;
            pad_q    <= 1'b1;
            lenblk_q <= 1'b0;
          end
          rnd_q <= '0;
        end
        StPad: begin
          pad_q <= 1'b0;
          if (fill_q == 6'(LenStart - 1)) lenblk_q <= 1'b1;
        end
        StRound: rnd_q <= rnd_q + 6'd1;
        StAdd: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          rnd_q <= '0;
        end
        StOut: begin
          if (pop_i) begin
            oidx_q <= oidx_q + 3'd1;
            if (oidx_q == 3'd7) begin
              for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
              bits_q <= '0;
              fin_q  <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // working variables and schedule window
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      w_q[wr_addr[5:2]][8*(3 - wr_addr[1:0]) +: 8] <= wr_byte;
    end
    if (state_q != StRound && state_d == StRound) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end
    if (state_q == StRound) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the streaming SHA-256 hasher against a built-in digest predictor:
// directed messages around the padding boundaries, then random messages,
// with random idling on both sides and a long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import sha_pkg::*;

  localparam int unsigned CycleLimit = 2000000;

  logic      clk_i;
  logic      rst_ni;
  logic      push_i;
  logic      full_o;
  in_item_t  in_item_i;
  logic      empty_o;
  logic      pop_i;
  out_item_t out_item_o;

  // predictor state
  logic [31:0] hash_state [8];
  logic [7:0]  msg_block [64];
  int unsigned block_fill;
  logic [63:0] bit_count;

  out_item_t   digest_queue [$];
  int unsigned error_count;
  int unsigned request_count;
  int unsigned message_count;
  int unsigned word_count;
  int unsigned cycle_count;
  bit          quiet_mode;
  bit          hold_receiver;
  int unsigned hold_cycles;

  sha256_stream_hash dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .full_o     (full_o),
    .in_item_i  (in_item_i),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .out_item_o (out_item_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

  // one 64-round compression of msg_block into hash_state
  function automatic void hash_block();
    logic [31:0] sched [64];
    logic [31:0] wv [8];
    logic [31:0] t1;
    logic [31:0] t2;
    for (int i = 0; i < 16; i++)
      sched[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++)
      sched[i] = sched[i-16] + sched[i-7]
        + (ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3))
        + (ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10));
    for (int i = 0; i < 8; i++) wv[i] = hash_state[i];
    for (int i = 0; i < 64; i++) begin
      t1 = wv[7] + (ror32(wv[4], 6) ^ ror32(wv[4], 11) ^ ror32(wv[4], 25))
        + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + RoundK[i] + sched[i];
      t2 = (ror32(wv[0], 2) ^ ror32(wv[0], 13) ^ ror32(wv[0], 22))
        + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
      wv[7] = wv[6]; wv[6] = wv[5]; wv[5] = wv[4]; wv[4] = wv[3] + t1;
      wv[3] = wv[2]; wv[2] = wv[1]; wv[1] = wv[0]; wv[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += wv[i];
  endfunction

  function automatic void restart_hash();
    for (int i = 0; i < 8; i++) hash_state[i] = InitH[i];
    block_fill = 0;
    bit_count = '0;
  endfunction

  // expected digest words for one accepted request
  function automatic void predict_digest(in_item_t req);
    int unsigned pos;
    out_item_t word;
    if (req.byte_valid) begin
      msg_block[block_fill] = req.data_byte;
      block_fill++;
      bit_count += 64'd8;
      if (block_fill == 64) begin
        hash_block();
        block_fill = 0;
      end
    end
    if (!req.last) return;
    pos = block_fill;
    msg_block[pos++] = PadByte;
    if (pos > LenStart) begin
      while (pos < 64) msg_block[pos++] = 8'h00;
      hash_block();
      pos = 0;
    end
    while (pos < LenStart) msg_block[pos++] = 8'h00;
    for (int i = 0; i < 8; i++) msg_block[63-i] = bit_count[8*i +: 8];
    hash_block();
    for (int i = 0; i < 8; i++) begin
      word.digest_word = hash_state[i];
      word.word_index  = 3'(i);
      word.last_word   = (i == 7);
      digest_queue.push_back(word);
    end
    restart_hash();
  endfunction

  // send one request, with a random gap unless quiet
  task automatic send_request(logic [7:0] b, logic v, logic l);
    int unsigned gap;
    if (!quiet_mode && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      push_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push_i    <= 1'b1;
    in_item_i <= '{data_byte: b, byte_valid: v, last: l};
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    predict_digest('{data_byte: b, byte_valid: v, last: l});
    request_count++;
    if (l) message_count++;
  endtask

  task automatic stop_sending();
    push_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_message(int unsigned len, bit last_with_byte);
    for (int i = 0; i < len; i++)
      send_request(8'($urandom), 1'b1, last_with_byte && (i == len - 1));
    if (!last_with_byte || len == 0) send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    stop_sending();
    while (digest_queue.size() != 0) @(posedge clk_i);
  endtask

  // result checker and receiver idling
  always @(posedge clk_i) begin
    if (rst_ni && pop_i && !empty_o) begin
      if (digest_queue.size() == 0) begin
        $display("%0t: unexpected digest word %h", $time, out_item_o);
        error_count++;
      end else begin
        if (out_item_o.digest_word !== digest_queue[0].digest_word ||
            out_item_o.word_index !== digest_queue[0].word_index ||
            out_item_o.last_word !== digest_queue[0].last_word) begin
          $display("%0t: mismatch expected %h/%0d/%b actual %h/%0d/%b", $time,
                   digest_queue[0].digest_word, digest_queue[0].word_index,
                   digest_queue[0].last_word, out_item_o.digest_word,
                   out_item_o.word_index, out_item_o.last_word);
          error_count++;
        end
        void'(digest_queue.pop_front());
        word_count++;
      end
    end
    if (hold_receiver) begin
      pop_i <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      pop_i <= 1'b0;
    end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
      hold_cycles <= $urandom_range(1, 14) - 1;
      pop_i <= 1'b0;
    end else begin
      pop_i <= 1'b1;
    end
  end

  // empty, single byte, bit extremes, byte with last
  task automatic test_directed();
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'hff, 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'haa, 1'b0, 1'b0);
    send_request(8'h55, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);
    wait_drained();
  endtask

  // lengths around the padding and block boundaries
  task automatic test_boundaries();
    send_message(55, 1'b1);
    send_message(56, 1'b0);
    send_message(64, 1'b1);
    wait_drained();
  endtask

  // receiver stalls long while the sender keeps pushing
  task automatic test_backpressure();
    hold_receiver = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        hold_receiver = 1'b0;
      end
      begin
        send_message(3, 1'b1);
        send_message(2, 1'b0);
        send_message(4, 1'b1);
        stop_sending();
      end
    join
    wait_drained();
  endtask

  // random messages, mostly short, with idle requests mixed in
  task automatic test_random(int unsigned budget);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < budget) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 72) : $urandom_range(0, 20);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) send_request(8'($urandom), 1'b0, 1'b0);
        send_request(8'($urandom), 1'b1, 1'b0);
      end
      send_request(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
      sent += len + 1;
    end
    wait_drained();
  endtask

  initial begin
    rst_ni        = 1'b0;
    push_i        = 1'b0;
    pop_i         = 1'b0;
    in_item_i     = '0;
    error_count   = 0;
    request_count = 0;
    message_count = 0;
    word_count    = 0;
    cycle_count   = 0;
    quiet_mode    = 1'b0;
    hold_receiver = 1'b0;
    hold_cycles   = 0;
    restart_hash();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_boundaries();
    test_backpressure();
    test_random(40);
    quiet_mode = 1'b1;
    test_random(25);
    repeat (200) @(posedge clk_i);

    $display("tb: %0d requests, %0d messages, %0d digest words checked",
             request_count, message_count, word_count);
    if (error_count == 0 && digest_queue.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
